@@ rtl/dsc_pkg.sv @@
`timescale 1ns / 1ps

package dsc_pkg;

    // Recognizer states: Q1..Q8, then the two decided states
    typedef enum logic [3:0] {
        ST_Q1  = 4'd0,
        ST_Q2  = 4'd1,
        ST_Q3  = 4'd2,
        ST_Q4  = 4'd3,
        ST_Q5  = 4'd4,
        ST_Q6  = 4'd5,
        ST_Q7  = 4'd6,
        ST_Q8  = 4'd7,
        ST_ACC = 4'd8,
        ST_REJ = 4'd9
    } rec_state_t;

    typedef enum logic [1:0] {
        VD_PENDING  = 2'd0,
        VD_ACCEPTED = 2'd1,
        VD_REJECTED = 2'd2
    } verdict_t;

    // Single operator held open until the next character shows whether it pairs up
    typedef enum logic [1:0] {
        OP_MINUS = 2'd0,
        OP_PLUS  = 2'd1,
        OP_LT    = 2'd2,
        OP_GT    = 2'd3
    } pend_op_t;

    // Per-character answer handed from the core to the output stage
    typedef struct packed {
        verdict_t verdict;
        logic     final_res;
    } dsc_result_t;

endpackage

@@ rtl/declaration_syntax_checker.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Ports                              Contents
// s_        in   s_tvalid s_tready s_tdata s_tlast  one source character, tlast = end of line
// m_        out  m_tvalid m_tready m_tdata          verdict and final flag for that character
//
// Each character is answered as it is taken: the lexer and recognizer update in a single
// combinational pass and the answer is registered in the output register (or the skid entry).
// Sustained rate is one character per cycle while m_tready is high, set by the state registers of the core.
// A two-entry output buffer (output register plus skid) lets s_tready stay high while
// one answer waits; s_tready drops only when both entries are full.
// Reset (aresetn low, synchronous) empties the buffer and returns the checker to the
// start of a line; after a character with tlast the checker restarts on its own.

module declaration_syntax_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] verdict, [2] final_res, [7:3] zero
);
    import dsc_pkg::*;

    logic        in_accept;
    dsc_result_t core_result;

    logic        main_valid_reg, main_valid_next;
    dsc_result_t main_reg, main_next;
    logic        skid_valid_reg, skid_valid_next;
    dsc_result_t skid_reg, skid_next;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;

    dsc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .ch        (s_tdata),
        .last      (s_tlast),
        .result    (core_result)
    );

    always_comb begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_accept;
                main_next       = core_result;
            end
        end else if (in_accept) begin
            skid_valid_next = 1'b1;
            skid_next       = core_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {5'd0, main_reg.final_res, main_reg.verdict};

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");

    a_final_matches_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == (m_tdata[1:0] != VD_PENDING)))
        else $error("final flag disagrees with verdict");

    a_skid_fills_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        main_valid_reg && !m_tready && in_accept |=> skid_valid_reg)
        else $error("transaction lost during output stall");

endmodule

@@ rtl/dsc_core.sv @@
`timescale 1ns / 1ps

module dsc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          ch,
    input  logic                last,
    output dsc_pkg::dsc_result_t result
);
    import dsc_pkg::*;

    typedef enum logic [2:0] {
        TK_IDLE = 3'd0,
        TK_WORD = 3'd1,
        TK_NUM  = 3'd2,
        TK_STR  = 3'd3,
        TK_OP   = 3'd4
    } tok_kind_t;

    typedef enum logic [3:0] {
        C_TYPE, C_BOOL, C_WORD, C_NUMD, C_NUMDOTV, C_DOT, C_STR, C_STROPEN,
        C_SEMI, C_COMMA, C_LBR, C_RBR, C_EQ, C_OP, C_END, C_BAD
    } tclass_t;

    typedef struct packed {
        logic [2:0] len;
        logic [9:0] cand;
    } word_t;

    localparam logic [9:0] CAND_ALL = 10'h3FF;
    localparam logic [2:0] LEN_MAX  = 3'd7;

    // number flags: bit0 began with '.', bit1 dot seen, bit2 digit seen
    localparam int NF_DOTSTART = 0;
    localparam int NF_DOT      = 1;
    localparam int NF_DIGIT    = 2;

    localparam logic [7:0] KW_TEXT [10][8] = '{
        '{0:"i", 1:"n", 2:"t", default:8'h00},
        '{0:"f", 1:"l", 2:"o", 3:"a", 4:"t", default:8'h00},
        '{0:"c", 1:"h", 2:"a", 3:"r", default:8'h00},
        '{0:"s", 1:"t", 2:"r", 3:"i", 4:"n", 5:"g", default:8'h00},
        '{0:"b", 1:"o", 2:"o", 3:"l", default:8'h00},
        '{0:"d", 1:"o", 2:"u", 3:"b", 4:"l", 5:"e", default:8'h00},
        '{0:"l", 1:"o", 2:"n", 3:"g", default:8'h00},
        '{0:"s", 1:"h", 2:"o", 3:"r", 4:"t", default:8'h00},
        '{0:"t", 1:"r", 2:"u", 3:"e", default:8'h00},
        '{0:"f", 1:"a", 2:"l", 3:"s", 4:"e", default:8'h00}
    };
    localparam logic [2:0] KW_LEN [10] = '{
        3'd3, 3'd5, 3'd4, 3'd6, 3'd4, 3'd6, 3'd4, 3'd5, 3'd4, 3'd5
    };

    rec_state_t rs_reg, rs_next;
    tok_kind_t  tk_reg, tk_next;
    pend_op_t   po_reg, po_next;
    logic [2:0] wl_reg, wl_next;
    logic [9:0] kc_reg, kc_next;
    logic [2:0] nf_reg, nf_next;

    function automatic logic is_done(input rec_state_t s);
        return (s == ST_ACC) || (s == ST_REJ);
    endfunction

    function automatic rec_state_t feed(input rec_state_t s, input tclass_t t);
        rec_state_t n;
        logic       num;
        n   = ST_REJ;
        num = (t == C_NUMD) || (t == C_NUMDOTV);
        if (is_done(s)) begin
            n = s;
        end else if (t == C_END) begin
            n = (s == ST_Q4) ? ST_ACC : ST_REJ;
        end else if (t != C_BAD) begin
            case (s)
                ST_Q1: if (t == C_TYPE) n = ST_Q2;
                ST_Q2: if (t != C_NUMD) n = ST_Q3;
                ST_Q3: begin
                    if (t == C_SEMI) n = ST_Q4;
                    else if (t == C_COMMA) n = ST_Q2;
                    else if (t == C_LBR) n = ST_Q5;
                    else if (t == C_EQ) n = ST_Q8;
                end
                ST_Q4: if (t == C_TYPE) n = ST_Q2;
                ST_Q5: if (num) n = ST_Q6;
                ST_Q6: if (t == C_RBR) n = ST_Q7;
                ST_Q7: begin
                    if (t == C_SEMI) n = ST_Q4;
                    else if (t == C_COMMA) n = ST_Q2;
                end
                ST_Q8: if (t == C_BOOL || num || t == C_STR) n = ST_Q7;
                default: n = ST_REJ;
            endcase
        end
        return n;
    endfunction

    // Narrow the keyword candidates by one letter; past seven letters none survive
    function automatic word_t word_char(input word_t w, input logic [7:0] c);
        word_t r;
        r.len  = w.len;
        r.cand = '0;
        if (w.len < LEN_MAX) begin
            for (int k = 0; k < 10; k++) begin
                if (w.cand[k] && (w.len < KW_LEN[k]) && (KW_TEXT[k][w.len] == c))
                    r.cand[k] = 1'b1;
            end
            r.len = w.len + 3'd1;
        end
        return r;
    endfunction

    function automatic tclass_t word_class(input word_t w);
        logic [9:0] hit;
        for (int k = 0; k < 10; k++)
            hit[k] = w.cand[k] && (KW_LEN[k] == w.len);
        if (|hit[7:0]) return C_TYPE;
        if (|hit[9:8]) return C_BOOL;
        return C_WORD;
    endfunction

    function automatic tclass_t num_class(input logic [2:0] nf);
        if (!nf[NF_DOTSTART]) return C_NUMD;
        return nf[NF_DIGIT] ? C_NUMDOTV : C_DOT;
    endfunction

    // Close whatever token is open and hand it to the recognizer
    function automatic rec_state_t close_feed(input rec_state_t s, input tok_kind_t tk,
                                              input word_t w, input logic [2:0] nf);
        rec_state_t n;
        case (tk)
            TK_WORD: n = feed(s, word_class(w));
            TK_NUM:  n = feed(s, num_class(nf));
            TK_STR:  n = feed(s, C_STROPEN);
            TK_OP:   n = feed(s, C_OP);
            default: n = s;
        endcase
        return n;
    endfunction

    always_comb begin
        rec_state_t s;
        tok_kind_t  tk;
        pend_op_t   po;
        word_t      w;
        logic [2:0] nf;
        logic       used;
        logic       lower;
        logic       digit;
        logic [7:0] partner;

        s       = rs_reg;
        tk      = tk_reg;
        po      = po_reg;
        w.len   = wl_reg;
        w.cand  = kc_reg;
        nf      = nf_reg;
        used    = 1'b0;
        lower   = (ch >= "a") && (ch <= "z");
        digit   = (ch >= "0") && (ch <= "9");
        case (po_reg)
            OP_MINUS: partner = "-";
            OP_PLUS:  partner = "+";
            default:  partner = "=";
        endcase

        if (!is_done(s)) begin
            case (tk)
                TK_WORD: begin
                    if (lower || digit) begin
                        w    = word_char(w, ch);
                        used = 1'b1;
                    end else begin
                        s  = close_feed(s, tk, w, nf);
                        tk = TK_IDLE;
                    end
                end
                TK_NUM: begin
                    if (digit) begin
                        nf[NF_DIGIT] = 1'b1;
                        used         = 1'b1;
                    end else if (ch == "." && !nf[NF_DOT]) begin
                        nf[NF_DOT] = 1'b1;
                        used       = 1'b1;
                    end else begin
                        s  = close_feed(s, tk, w, nf);
                        tk = TK_IDLE;
                    end
                end
                TK_STR: begin
                    if (ch == "\"") begin
                        tk = TK_IDLE;
                        s  = feed(s, C_STR);
                    end
                    used = 1'b1;
                end
                TK_OP: begin
                    used = (ch == partner);
                    s    = close_feed(s, tk, w, nf);
                    tk   = TK_IDLE;
                end
                default: ;
            endcase

            if (!used && !is_done(s)) begin
                if (ch == " ") begin
                    // separator only
                end else if (ch == "\"") begin
                    tk = TK_STR;
                end else if (lower) begin
                    tk     = TK_WORD;
                    w.len  = 3'd0;
                    w.cand = CAND_ALL;
                    w      = word_char(w, ch);
                end else if (digit || ch == ".") begin
                    tk = TK_NUM;
                    nf = digit ? 3'b100 : 3'b011;
                end else if (ch == "-") begin
                    tk = TK_OP;
                    po = OP_MINUS;
                end else if (ch == "+") begin
                    tk = TK_OP;
                    po = OP_PLUS;
                end else if (ch == "<") begin
                    tk = TK_OP;
                    po = OP_LT;
                end else if (ch == ">") begin
                    tk = TK_OP;
                    po = OP_GT;
                end else if (ch == ";") begin
                    s = feed(s, C_SEMI);
                end else if (ch == ",") begin
                    s = feed(s, C_COMMA);
                end else if (ch == "[") begin
                    s = feed(s, C_LBR);
                end else if (ch == "]") begin
                    s = feed(s, C_RBR);
                end else if (ch == "=") begin
                    s = feed(s, C_EQ);
                end else if (ch == "(" || ch == ")" || ch == "*" || ch == "/") begin
                    s = feed(s, C_OP);
                end else if (ch == "$") begin
                    s = feed(s, C_END);
                end else begin
                    s = feed(s, C_BAD);
                end
            end

            if (last && !is_done(s)) begin
                s  = close_feed(s, tk, w, nf);
                tk = TK_IDLE;
                s  = feed(s, C_END);
            end
        end

        if (is_done(s)) begin
            result.verdict   = (s == ST_ACC) ? VD_ACCEPTED : VD_REJECTED;
            result.final_res = 1'b1;
        end else begin
            result.verdict   = VD_PENDING;
            result.final_res = 1'b0;
        end

        if (last) begin
            rs_next = ST_Q1;
            tk_next = TK_IDLE;
            po_next = OP_MINUS;
            wl_next = 3'd0;
            kc_next = CAND_ALL;
            nf_next = 3'd0;
        end else begin
            rs_next = s;
            tk_next = tk;
            po_next = po;
            wl_next = w.len;
            kc_next = w.cand;
            nf_next = nf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_reg <= ST_Q1;
            tk_reg <= TK_IDLE;
            po_reg <= OP_MINUS;
            wl_reg <= 3'd0;
            kc_reg <= CAND_ALL;
            nf_reg <= 3'd0;
        end else if (in_accept) begin
            rs_reg <= rs_next;
            tk_reg <= tk_next;
            po_reg <= po_next;
            wl_reg <= wl_next;
            kc_reg <= kc_next;
            nf_reg <= nf_next;
        end
    end

    a_line_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && last |=> rs_reg == ST_Q1 && tk_reg == TK_IDLE && kc_reg == CAND_ALL)
        else $error("state not cleared after end of line");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_accept |=> $stable(rs_reg) && $stable(tk_reg))
        else $error("lexer state moved without a transaction");

    a_word_has_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        tk_reg == TK_WORD |-> wl_reg != 3'd0)
        else $error("open word token with zero length");

endmodule
